// ----- src/bia_pkg.sv -----
// bia_pkg: shared constants, operation codes and controller/datapath interface types
package bia_pkg;

    // word field widths
    localparam int FUNC_W      = 2;
    localparam int ENTRY_ID_W  = 10;
    localparam int ROW_INDEX_W = 5;
    localparam int ROW_DATA_W  = 32;
    localparam int LIMIT_W     = 11;
    localparam int ALLOC_ID_W  = 10;

    // packed stream widths
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = FUNC_W;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 1;

    // defaults for the top level parameters
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_ROW_BITS    = 32;

    // rows of the full-row summary examined per scan cycle
    localparam int SCAN_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECLAIM = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clr;        // clearing pass, one row
        logic capture;    // take in a new word
        logic scan;       // search one chunk of the full-row summary
        logic find;       // pick the free bit in the fetched row
        logic div1;       // reclaim id split, first step
        logic div2;       // reclaim id split, second step and row fetch
        logic rchk;       // reclaim check and clear
        logic load;       // write a whole row
        logic resp_push;  // move the result into the output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
        logic chunk_hit;
        logic chunk_last;
        logic out_free;
    } sts_t;

endpackage

// ----- src/bia_ctrl.sv -----
// bia_ctrl: operation sequencer for the bitmap id allocator
module bia_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic [bia_pkg::FUNC_W-1:0]        func,
    input  bia_pkg::sts_t                     sts,
    output bia_pkg::cmd_t                     cmd,
    output logic                              in_ready
);
    import bia_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_SCAN  = 4'd2;
    localparam logic [3:0] ST_FIND  = 4'd3;
    localparam logic [3:0] ST_DIV1  = 4'd4;
    localparam logic [3:0] ST_DIV2  = 4'd5;
    localparam logic [3:0] ST_RCHK  = 4'd6;
    localparam logic [3:0] ST_LOAD  = 4'd7;
    localparam logic [3:0] ST_RESP  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    unique case (func)
                        FUNC_ALLOC:   state_next = ST_SCAN;
                        FUNC_RECLAIM: state_next = ST_DIV1;
                        FUNC_LOAD:    state_next = ST_LOAD;
                        default:      state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.chunk_hit)
                begin
                    state_next = ST_FIND;
                end
                else if (sts.chunk_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = ST_RESP;
            end
            ST_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                cmd.div2   = 1'b1;
                state_next = ST_RCHK;
            end
            ST_RCHK:
            begin
                cmd.rchk   = 1'b1;
                state_next = ST_RESP;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.resp_push = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/bia_datapath.sv -----
// bia_datapath: bitmap memory, full-row summary, search, id split and result registers
module bia_datapath #(
    parameter int MAX_ENTRIES = bia_pkg::DEF_MAX_ENTRIES,
    parameter int ROW_BITS    = bia_pkg::DEF_ROW_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bia_pkg::cmd_t                       cmd,
    output bia_pkg::sts_t                       sts,
    input  logic                                cfg_we,
    input  logic [bia_pkg::LIMIT_W-1:0]         cfg_data,
    input  logic [bia_pkg::ENTRY_ID_W-1:0]      entry_id,
    input  logic [bia_pkg::ROW_INDEX_W-1:0]     row_index,
    input  logic [bia_pkg::ROW_DATA_W-1:0]      row_bits,
    input  logic                                m_tready,
    output logic                                m_valid,
    output logic                                out_ok,
    output logic [bia_pkg::ALLOC_ID_W-1:0]      out_id
);
    import bia_pkg::*;

    localparam int ROW_COUNT  = (MAX_ENTRIES + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int COL_W      = $clog2(ROW_BITS);
    localparam int NUM_CHUNKS = (ROW_COUNT + SCAN_W - 1) / SCAN_W;
    localparam int CHK_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int POS_W      = $clog2(SCAN_W);
    localparam int FROW_W     = CHK_W + POS_W;
    localparam int PAD_W      = NUM_CHUNKS * SCAN_W - ROW_COUNT;
    localparam int ID_W       = $clog2(ROW_COUNT * ROW_BITS);
    localparam int LIM_W      = (LIMIT_W > $clog2(MAX_ENTRIES + 1)) ?
                                LIMIT_W : $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W      = (ID_W > LIM_W) ? ID_W : LIM_W;
    // reciprocal split of a reclaim id into row and column
    localparam int DIV_SH     = ENTRY_ID_W + 7;
    localparam int RECIP      = (2 ** DIV_SH) / ROW_BITS;
    localparam int RECIP_W    = DIV_SH - 2;
    localparam int PROD_W     = ENTRY_ID_W + RECIP_W;
    localparam int Q_W        = PROD_W - DIV_SH;
    localparam int MUL_W      = Q_W + 7;

    // bitmap storage
    logic [ROW_BITS-1:0]   mem [0:ROW_COUNT-1];
    logic [ROW_COUNT-1:0]  full_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [ROW_W-1:0]      clr_ptr_reg;
    logic [CHK_W-1:0]      chunk_ptr_reg;

    // captured word
    logic [ENTRY_ID_W-1:0]  entry_id_reg;
    logic [ROW_INDEX_W-1:0] row_index_reg;
    logic [ROW_DATA_W-1:0]  row_bits_reg;

    logic [PROD_W-1:0]     prod_reg;
    logic                  in_range_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_BITS-1:0]   rd_data_reg;
    logic                  res_ok_reg;
    logic [ALLOC_ID_W-1:0] res_id_reg;
    logic                  m_valid_reg;
    logic                  out_ok_reg;
    logic [ALLOC_ID_W-1:0] out_id_reg;

    logic [NUM_CHUNKS*SCAN_W-1:0] sum_pad;
    logic [SCAN_W-1:0]     chunk_bits;
    logic                  chunk_hit;
    logic [POS_W-1:0]      hit_pos;
    logic [FROW_W-1:0]     found_wide;
    logic [ROW_W-1:0]      found_row;
    logic                  chunk_last;

    logic [LIM_W-1:0]      lim_eff;
    logic                  zero_hit;
    logic [COL_W-1:0]      zero_col;
    logic [CMP_W-1:0]      alloc_id_c;
    logic                  alloc_ok;
    logic [ROW_BITS-1:0]   set_data;
    logic                  rchk_ok;
    logic [ROW_BITS-1:0]   clr_data;
    logic                  load_ok;

    logic [Q_W-1:0]        q_est;
    logic [MUL_W-1:0]      qrb;
    logic [ENTRY_ID_W-1:0] rem;
    logic                  rem_hi;
    logic [Q_W-1:0]        q_fix;
    logic [ENTRY_ID_W-1:0] col_fix;

    logic                  rd_en;
    logic [ROW_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [ROW_W-1:0]      wr_addr;
    logic [ROW_BITS-1:0]   wr_data;

    // rows past the end read as full so the scan never picks them
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign sum_pad = {{PAD_W{1'b1}}, full_reg};
        end
        else
        begin : g_nopad
            assign sum_pad = full_reg;
        end
    endgenerate

    assign chunk_bits = sum_pad[chunk_ptr_reg * SCAN_W +: SCAN_W];
    assign chunk_last = (chunk_ptr_reg == CHK_W'(NUM_CHUNKS - 1));

    always_comb
    begin
        chunk_hit = 1'b0;
        hit_pos   = '0;
        for (int i = SCAN_W - 1; i >= 0; i--)
        begin
            if (!chunk_bits[i])
            begin
                chunk_hit = 1'b1;
                hit_pos   = POS_W'(i);
            end
        end
    end

    assign found_wide = {chunk_ptr_reg, hit_pos};
    assign found_row  = ROW_W'(found_wide);

    assign lim_eff = (LIM_W'(limit_reg) > LIM_W'(MAX_ENTRIES)) ?
                     LIM_W'(MAX_ENTRIES) : LIM_W'(limit_reg);

    // lowest free bit of the fetched row
    always_comb
    begin
        zero_hit = 1'b0;
        zero_col = '0;
        for (int j = ROW_BITS - 1; j >= 0; j--)
        begin
            if (!rd_data_reg[j])
            begin
                zero_hit = 1'b1;
                zero_col = COL_W'(j);
            end
        end
    end

    assign alloc_id_c = CMP_W'(row_reg) * CMP_W'(ROW_BITS) + CMP_W'(zero_col);
    assign alloc_ok   = zero_hit && (alloc_id_c < CMP_W'(lim_eff));
    assign set_data   = rd_data_reg | (ROW_BITS'(1) << zero_col);

    assign rchk_ok  = in_range_reg && rd_data_reg[col_reg];
    assign clr_data = rd_data_reg & ~(ROW_BITS'(1) << col_reg);

    assign load_ok = (int'(row_index_reg) < ROW_COUNT);

    // estimate may fall one short, one compare fixes it
    assign q_est   = prod_reg[PROD_W-1:DIV_SH];
    assign qrb     = MUL_W'(q_est) * MUL_W'(ROW_BITS);
    assign rem     = entry_id_reg - ENTRY_ID_W'(qrb);
    assign rem_hi  = (rem >= ENTRY_ID_W'(ROW_BITS));
    assign q_fix   = rem_hi ? (q_est + Q_W'(1)) : q_est;
    assign col_fix = rem_hi ? (rem - ENTRY_ID_W'(ROW_BITS)) : rem;

    assign rd_en   = (cmd.scan && chunk_hit) || (cmd.div2 && in_range_reg);
    assign rd_addr = cmd.scan ? found_row : ROW_W'(q_fix);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_reg;
        wr_data = '0;
        if (cmd.clr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_ptr_reg;
        end
        else if (cmd.find && alloc_ok)
        begin
            wr_en   = 1'b1;
            wr_data = set_data;
        end
        else if (cmd.rchk && rchk_ok)
        begin
            wr_en   = 1'b1;
            wr_data = clr_data;
        end
        else if (cmd.load && load_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = ROW_W'(row_index_reg);
            wr_data = ROW_BITS'(row_bits_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            full_reg      <= '0;
            clr_ptr_reg   <= '0;
            chunk_ptr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (wr_en)
            begin
                full_reg[wr_addr] <= &wr_data;
            end
            if (cmd.clr)
            begin
                clr_ptr_reg <= clr_ptr_reg + ROW_W'(1);
            end
            if (cmd.capture)
            begin
                chunk_ptr_reg <= '0;
            end
            else if (cmd.scan && !chunk_hit && !chunk_last)
            begin
                chunk_ptr_reg <= chunk_ptr_reg + CHK_W'(1);
            end
            if (cmd.resp_push)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            entry_id_reg  <= entry_id;
            row_index_reg <= row_index;
            row_bits_reg  <= row_bits;
        end
        if (cmd.div1)
        begin
            prod_reg     <= PROD_W'(entry_id_reg) * PROD_W'(RECIP);
            in_range_reg <= (CMP_W'(entry_id_reg) < CMP_W'(lim_eff));
        end
        if (cmd.scan)
        begin
            row_reg <= found_row;
        end
        else if (cmd.div2)
        begin
            row_reg <= ROW_W'(q_fix);
            col_reg <= COL_W'(col_fix);
        end
        if (cmd.capture)
        begin
            res_ok_reg <= 1'b0;
            res_id_reg <= '0;
        end
        else if (cmd.find)
        begin
            res_ok_reg <= alloc_ok;
            res_id_reg <= alloc_ok ? ALLOC_ID_W'(alloc_id_c) : '0;
        end
        else if (cmd.rchk)
        begin
            res_ok_reg <= rchk_ok;
        end
        else if (cmd.load)
        begin
            res_ok_reg <= load_ok;
        end
        if (cmd.resp_push)
        begin
            out_ok_reg <= res_ok_reg;
            out_id_reg <= res_id_reg;
        end
    end

    assign sts.clr_last   = (clr_ptr_reg == ROW_W'(ROW_COUNT - 1));
    assign sts.chunk_hit  = chunk_hit;
    assign sts.chunk_last = chunk_last;
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_valid = m_valid_reg;
    assign out_ok  = out_ok_reg;
    assign out_id  = out_id_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resp_push |-> (!m_valid_reg || m_tready))
        else $error("result pushed over an untaken word");

    a_id_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !out_ok_reg) |-> (out_id_reg == '0))
        else $error("failed result carries a nonzero id");

    a_scan_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && chunk_hit) |-> (int'(found_wide) < ROW_COUNT))
        else $error("summary scan picked a row past the end");

    a_find_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.find |-> $past(cmd.scan && chunk_hit))
        else $error("bit search without a fetched row");

endmodule

// ----- src/bitmap_id_allocator_core.sv -----
// bitmap_id_allocator_core: top level of the first-free bitmap id allocator
//
// Hands out and takes back identifiers from a used/free bitmap of MAX_ENTRIES
// ids kept in rows of ROW_BITS bits (bit j of row r is id r*ROW_BITS+j). Each
// input word carries one request and gives exactly one result word. Allocate
// grants the lowest free id below the effective limit (entry_limit, capped at
// MAX_ENTRIES) and marks it used; reclaim frees a used id below that limit;
// load overwrites a whole row. Any failure, an unused operation code included,
// answers ok low with a zero id. After reset the block sweeps the bitmap to
// zero, one row a cycle, and takes no request during that time; entry_limit
// can be written at any time the block is idle. One request is worked on at
// a time. After the accept, load writes its row; reclaim splits the id into
// row and column and fetches that row, then checks and clears the bit;
// allocate walks the 32-row groups of the full-row summary until a non-full
// row turns up and fetches it, then searches and sets its lowest free bit;
// an unused code goes straight to the result. When every row is full the
// walk covers all groups and the bit search is skipped. The bitmap memory
// with its registered read splits every read-modify-write into a fetch step
// and an update step. The result sits in an output register, so a stalled
// consumer holds only the next result, not the accept.
module bitmap_id_allocator_core #(
    parameter int MAX_ENTRIES = bia_pkg::DEF_MAX_ENTRIES,
    parameter int ROW_BITS    = bia_pkg::DEF_ROW_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel: entry_limit
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bia_pkg::LIMIT_W-1:0]         cfg_data,
    // request words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bia_pkg::IN_TDATA_W-1:0]      s_tdata,   // entry_id[9:0], row_index[14:10],
                                                           // row_bits[46:15], zero[47]
    input  logic [bia_pkg::IN_TUSER_W-1:0]      s_tuser,   // func[1:0]
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bia_pkg::OUT_TDATA_W-1:0]     m_tdata,   // allocated_id[9:0], zero[15:10]
    output logic [bia_pkg::OUT_TUSER_W-1:0]     m_tuser    // ok[0]
);
    import bia_pkg::*;

    cmd_t                   cmd;
    sts_t                   sts;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func;
    logic [ENTRY_ID_W-1:0]  entry_id;
    logic [ROW_INDEX_W-1:0] row_index;
    logic [ROW_DATA_W-1:0]  row_bits;
    logic                   out_ok;
    logic [ALLOC_ID_W-1:0]  out_id;

    // unpack the request word
    assign func      = s_tuser[FUNC_W-1:0];
    assign entry_id  = s_tdata[ENTRY_ID_W-1:0];
    assign row_index = s_tdata[ENTRY_ID_W +: ROW_INDEX_W];
    assign row_bits  = s_tdata[ENTRY_ID_W + ROW_INDEX_W +: ROW_DATA_W];

    // the limit register takes a write in any cycle
    assign cfg_ready = 1'b1;
    assign s_tready  = in_ready;

    // sequencer: clearing pass, then one request at a time
    bia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (in_ready)
    );

    // bitmap memory, summary search, id split and output register
    bia_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ROW_BITS    (ROW_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .entry_id  (entry_id),
        .row_index (row_index),
        .row_bits  (row_bits),
        .m_tready  (m_tready),
        .m_valid   (m_tvalid),
        .out_ok    (out_ok),
        .out_id    (out_id)
    );

    // pack the result word, unused high bits tied low
    assign m_tdata = {{(OUT_TDATA_W - ALLOC_ID_W){1'b0}}, out_id};
    assign m_tuser = out_ok;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking stream testbench for the first-free bitmap id allocator
module tb;
    import bia_pkg::*;

    localparam int MAX_IDS     = DEF_MAX_ENTRIES;
    localparam int ROW_W       = DEF_ROW_BITS;
    localparam int ROW_CNT     = (MAX_IDS + ROW_W - 1) / ROW_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_WORDS = 230;

    // code with no operation behind it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [ENTRY_ID_W-1:0]  entry_id;
        logic [ROW_INDEX_W-1:0] row_index;
        logic [ROW_DATA_W-1:0]  row_bits;
    } request_t;

    typedef struct packed {
        logic                  ok;
        logic [ALLOC_ID_W-1:0] grant_id;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LIMIT_W-1:0]     cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    bitmap_id_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // shadow of the allocator state
    logic [ROW_W-1:0]   shadow_map [ROW_CNT];
    logic [LIMIT_W-1:0] shadow_limit = LIMIT_RESET;

    request_t request_q [$];
    reply_t   reply_q [$];

    int  error_cnt = 0;
    int  sent_cnt = 0;
    int  checked_cnt = 0;
    int  grant_cnt = 0;
    int  refuse_cnt = 0;
    int  cfg_cnt = 0;
    int  cycle_cnt = 0;
    bit  quiet = 1'b0;
    bit  hold_request = 1'b0;
    bit  hold_started = 1'b0;

    initial
    begin
        for (int r = 0; r < ROW_CNT; r++)
            shadow_map[r] = '0;
    end

    function automatic int unsigned id_cap();
        return (shadow_limit > MAX_IDS) ? MAX_IDS : shadow_limit;
    endfunction

    // applies one request to the shadow state and returns the reply word it earns
    function automatic reply_t allocator_reply(request_t rq);
        int unsigned cap;
        int unsigned id;
        reply_t      rp;
        rp = '0;
        cap = id_cap();
        case (rq.func)
            FUNC_ALLOC:
            begin
                for (id = 0; id < cap && !rp.ok; id++)
                begin
                    if (!shadow_map[id / ROW_W][id % ROW_W])
                    begin
                        shadow_map[id / ROW_W][id % ROW_W] = 1'b1;
                        rp.ok = 1'b1;
                        rp.grant_id = id[ALLOC_ID_W-1:0];
                    end
                end
            end
            FUNC_RECLAIM:
            begin
                id = 32'(rq.entry_id);
                if (id < cap && shadow_map[id / ROW_W][id % ROW_W])
                begin
                    shadow_map[id / ROW_W][id % ROW_W] = 1'b0;
                    rp.ok = 1'b1;
                end
            end
            FUNC_LOAD:
            begin
                if (rq.row_index < ROW_CNT)
                begin
                    shadow_map[rq.row_index] = rq.row_bits;
                    rp.ok = 1'b1;
                end
            end
            default: ;
        endcase
        return rp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch at reply %0d: %s got %0h want %0h",
                 checked_cnt, what, got, want);
        error_cnt++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        request_t offered;
        int       send_gap;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                reply_q.push_back(allocator_reply(offered));
                sent_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    offered = request_q.pop_front();
                    s_tdata  <= {1'b0, offered.row_bits, offered.row_index, offered.entry_id};
                    s_tuser  <= offered.func;
                    s_tvalid <= 1'b1;
                    if (!quiet && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // reply monitor with receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : monitor
        reply_t want;
        int     stall_left;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                begin
                    report_mismatch("reply with none pending", 32'(m_tdata), 32'd0);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tuser[0] !== want.ok)
                        report_mismatch("ok", 32'(m_tuser[0]), 32'(want.ok));
                    if (m_tdata[ALLOC_ID_W-1:0] !== want.grant_id)
                        report_mismatch("allocated_id", 32'(m_tdata[ALLOC_ID_W-1:0]),
                                        32'(want.grant_id));
                    if (m_tdata[OUT_TDATA_W-1:ALLOC_ID_W] !== '0)
                        report_mismatch("pad bits", 32'(m_tdata[OUT_TDATA_W-1:ALLOC_ID_W]),
                                        32'd0);
                    if (want.ok && want.grant_id != 0)
                        grant_cnt++;
                    if (!want.ok)
                        refuse_cnt++;
                end
                checked_cnt++;
            end
            // one long hold lets the block back up into its input
            if (hold_request && !hold_started)
            begin
                hold_started = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_cnt);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic queue_request(logic [FUNC_W-1:0] func, int unsigned id, int unsigned row,
                                 logic [ROW_DATA_W-1:0] bits);
        request_t rq;
        rq.func      = func;
        rq.entry_id  = id[ENTRY_ID_W-1:0];
        rq.row_index = row[ROW_INDEX_W-1:0];
        rq.row_bits  = bits;
        request_q.push_back(rq);
    endtask

    // random word: unused fields carry noise, reclaims mostly aim at used ids
    task automatic queue_random();
        request_t    rq;
        int unsigned pick;
        int unsigned cap;
        int unsigned start;
        int unsigned id;
        rq.func      = FUNC_UNUSED;
        rq.entry_id  = ENTRY_ID_W'($urandom_range(0, MAX_IDS - 1));
        rq.row_index = ROW_INDEX_W'($urandom_range(0, ROW_CNT - 1));
        rq.row_bits  = $urandom;
        cap = id_cap();
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            rq.func = FUNC_ALLOC;
        end
        else if (pick < 80)
        begin
            rq.func = FUNC_RECLAIM;
            if (cap > 0 && $urandom_range(0, 4) != 0)
            begin
                start = $urandom_range(0, cap - 1);
                for (int n = 0; n < cap; n++)
                begin
                    id = (start + n) % cap;
                    if (shadow_map[id / ROW_W][id % ROW_W])
                    begin
                        rq.entry_id = id[ENTRY_ID_W-1:0];
                        break;
                    end
                end
            end
        end
        else if (pick < 96)
        begin
            rq.func = FUNC_LOAD;
            case ($urandom_range(0, 4))
                0: rq.row_bits = '1;
                1: rq.row_bits = '0;
                2: rq.row_bits = $urandom & $urandom;
                3: rq.row_bits = ~(32'd1 << $urandom_range(0, ROW_W - 1));
                default: ;
            endcase
        end
        request_q.push_back(rq);
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || s_tvalid || reply_q.size() > 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow_limit = value;
        cfg_cnt++;
    endtask

    initial
    begin : stimulus
        int unsigned phase_limits [RAND_PHASES];
        int          drain;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset limit, first-free order, reclaim rules, row loads
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_RECLAIM, 1, 0, 0);
        queue_request(FUNC_RECLAIM, 1, 0, 0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_RECLAIM, MAX_IDS - 1, 0, 0);
        queue_request(FUNC_LOAD, 0, ROW_CNT - 1, '1);
        queue_request(FUNC_RECLAIM, MAX_IDS - 1, 0, 0);
        queue_request(FUNC_LOAD, 0, 0, '1);
        queue_request(FUNC_LOAD, 0, 1, 32'h7fff_ffff);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_UNUSED, $urandom_range(0, MAX_IDS - 1), $urandom, $urandom);
        queue_request(FUNC_LOAD, 0, 1, '0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        wait_drained();

        // limit above capacity acts as capacity
        write_limit('1);
        queue_request(FUNC_RECLAIM, MAX_IDS - 1, 0, 0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        wait_drained();

        // ids 0..32 all used: allocate refuses, used id above the limit stays put
        write_limit(11'd33);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_RECLAIM, 33, 0, 0);
        queue_request(FUNC_RECLAIM, 0, 0, 0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        wait_drained();

        write_limit('0);
        queue_request(FUNC_ALLOC, 0, 0, 0);
        queue_request(FUNC_RECLAIM, 0, 0, 0);
        wait_drained();

        phase_limits[0] = MAX_IDS;
        phase_limits[1] = (1 << LIMIT_W) - 1;
        phase_limits[2] = $urandom_range(2, MAX_IDS - 1);
        phase_limits[3] = 33;
        phase_limits[4] = 1;
        phase_limits[5] = $urandom_range(MAX_IDS + 1, (1 << LIMIT_W) - 1);
        phase_limits[6] = $urandom_range(0, (1 << LIMIT_W) - 1);
        phase_limits[7] = MAX_IDS;

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_drained();
            write_limit(phase_limits[p][LIMIT_W-1:0]);
            if (p == 0)
                hold_request = 1'b1;
            if (p == RAND_PHASES - 1)
                quiet = 1'b1;
            // start from a full map once and from an empty one once
            if (p == 1 || p == 5)
            begin
                for (int r = 0; r < ROW_CNT; r++)
                    queue_request(FUNC_LOAD, $urandom, r, (p == 1) ? '1 : '0);
            end
            // small batches keep the reclaim aim close to the real state
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                while (request_q.size() > 2)
                    @(posedge clk);
                queue_random();
            end
        end

        drain = 0;
        while ((request_q.size() > 0 || s_tvalid || reply_q.size() > 0) && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (reply_q.size() > 0)
            report_mismatch("replies never came", 32'(reply_q.size()), 32'd0);

        $display("tb: %0d request words sent, %0d replies checked over %0d limit settings",
                 sent_cnt, checked_cnt, cfg_cnt + 1);
        $display("tb: %0d nonzero grants, %0d refusals, %0d mismatches",
                 grant_cnt, refuse_cnt, error_cnt);
        if (error_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
src/bia_pkg.sv
src/bia_ctrl.sv
src/bia_datapath.sv
src/bitmap_id_allocator_core.sv
dv/tb.sv
